[rtl/pab_pkg.sv]
package pab_pkg;

  localparam int unsigned ChMax = 255;
  localparam int unsigned RoundAlpha = 127;
  localparam int unsigned NumW = 24;
  localparam int unsigned DenW = 16;
  localparam int unsigned QuoW = 9;

  typedef struct packed {
    logic [NumW-1:0] num_r;
    logic [NumW-1:0] num_g;
    logic [NumW-1:0] num_b;
    logic [NumW-1:0] rem_r;
    logic [NumW-1:0] rem_g;
    logic [NumW-1:0] rem_b;
    logic [QuoW-1:0] q_r;
    logic [QuoW-1:0] q_g;
    logic [QuoW-1:0] q_b;
    logic [DenW-1:0] den;
    logic [7:0] pass_r;
    logic [7:0] pass_g;
    logic [7:0] pass_b;
    logic [7:0] oa;
    logic bypass;
    logic zero;
  } div_data_t;

endpackage

[rtl/pixel_alpha_blend_unit.sv]
// straight-alpha source-over blend of one rgba8 source pixel onto one
// rgba8 destination pixel
// input: drive the eight channel ports and raise start; busy is always low,
// so an item is taken at every clock edge that sees start high
// output: done pulses for one cycle with out_red, out_green, out_blue and
// out_alpha; the receiver cannot hold results off and must take them then
// latency: 12 cycles from the start edge to the edge that takes the result
// (two cycles of products and output alpha, nine divider cells, one
// saturation and output register)
// throughput: one item per cycle; each of the nine cells works out one
// quotient bit of the three color divisions and hands on to the next cell
// reset: rst is synchronous and clears all valid bits; items in flight are
// dropped and no done pulse follows until new items arrive
module pixel_alpha_blend_unit
  import pab_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [7:0] src_red,
  input  logic [7:0] src_green,
  input  logic [7:0] src_blue,
  input  logic [7:0] src_alpha,
  input  logic [7:0] dst_red,
  input  logic [7:0] dst_green,
  input  logic [7:0] dst_blue,
  input  logic [7:0] dst_alpha,
  output logic done,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);

  logic vld [QuoW+1];
  div_data_t dat [QuoW+1];

  assign busy = 1'b0;

  pab_prep u_prep (
    .clk, .rst, .start,
    .src_red, .src_green, .src_blue, .src_alpha,
    .dst_red, .dst_green, .dst_blue, .dst_alpha,
    .vld(vld[0]), .data(dat[0])
  );

  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    pab_div_cell #(.Bit(QuoW - 1 - i)) u_cell (
      .clk, .rst,
      .in_vld(vld[i]), .in_data(dat[i]),
      .out_vld(vld[i+1]), .out_data(dat[i+1])
    );
  end

  function automatic logic [7:0] sat(input logic [QuoW-1:0] q);
    sat = (q > QuoW'(ChMax)) ? 8'(ChMax) : q[7:0];
  endfunction

  div_data_t fin;
  assign fin = dat[QuoW];

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vld[QuoW];
  end

  always_ff @(posedge clk) begin
    if (fin.bypass) begin
      out_red <= fin.pass_r;
      out_green <= fin.pass_g;
      out_blue <= fin.pass_b;
      out_alpha <= fin.oa;
    end else if (fin.zero) begin
      out_red <= '0;
      out_green <= '0;
      out_blue <= '0;
      out_alpha <= '0;
    end else begin
      out_red <= sat(fin.q_r);
      out_green <= sat(fin.q_g);
      out_blue <= sat(fin.q_b);
      out_alpha <= fin.oa;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> ##10 done)
    else $error("item lost in cell chain");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld[QuoW]))
    else $error("done without item");

  a_opaque: assert property (@(posedge clk) disable iff (rst)
    (vld[QuoW] && fin.bypass) |=> (out_alpha == $past(fin.oa)))
    else $error("bypass alpha mismatch");

endmodule

[rtl/pab_prep.sv]
module pab_prep
  import pab_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [7:0] src_red,
  input  logic [7:0] src_green,
  input  logic [7:0] src_blue,
  input  logic [7:0] src_alpha,
  input  logic [7:0] dst_red,
  input  logic [7:0] dst_green,
  input  logic [7:0] dst_blue,
  input  logic [7:0] dst_alpha,
  output logic vld,
  output div_data_t data
);

  // stage 1: products
  logic v1;
  logic [7:0] sa1, inv1, sr1, sg1, sb1, dr1, dg1, db1, da1;
  logic [15:0] da_inv1;
  logic [15:0] sa255;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      vld <= 1'b0;
    end else begin
      v1 <= start;
      vld <= v1;
    end
  end

  always_ff @(posedge clk) begin
    sa1 <= src_alpha;
    inv1 <= 8'(ChMax) - src_alpha;
    da_inv1 <= dst_alpha * (8'(ChMax) - src_alpha);
    sa255 <= src_alpha * 8'(ChMax);
    sr1 <= src_red; sg1 <= src_green; sb1 <= src_blue;
    dr1 <= dst_red; dg1 <= dst_green; db1 <= dst_blue; da1 <= dst_alpha;
  end

  // stage 2: output alpha and numerators
  logic [16:0] oa_sum;
  logic [16:0] oa_div;
  logic [8:0] oa_full;
  logic [7:0] oa;
  logic by;
  logic [7:0] pr, pg, pb, pa;

  always_comb begin
    oa_sum = {1'b0, da_inv1} + 17'(RoundAlpha);
    // divide by 255 as (x + (x >> 8) + 1) >> 8
    oa_div = oa_sum + 17'(oa_sum[16:8]) + 17'd1;
    oa_full = {1'b0, sa1} + oa_div[16:8];
    oa = (oa_full > 9'(ChMax)) ? 8'(ChMax) : oa_full[7:0];
    by = (sa1 == 8'd0) || (sa1 == 8'(ChMax));
    if (sa1 == 8'd0) begin
      pr = dr1; pg = dg1; pb = db1; pa = da1;
    end else begin
      pr = sr1; pg = sg1; pb = sb1; pa = sa1;
    end
  end

  always_ff @(posedge clk) begin
    data.num_r <= NumW'(sr1) * NumW'(sa255) + NumW'(dr1) * NumW'(da_inv1);
    data.num_g <= NumW'(sg1) * NumW'(sa255) + NumW'(dg1) * NumW'(da_inv1);
    data.num_b <= NumW'(sb1) * NumW'(sa255) + NumW'(db1) * NumW'(da_inv1);
    data.rem_r <= '0;
    data.rem_g <= '0;
    data.rem_b <= '0;
    data.q_r <= '0;
    data.q_g <= '0;
    data.q_b <= '0;
    data.den <= DenW'(oa) * DenW'(ChMax);
    data.pass_r <= pr;
    data.pass_g <= pg;
    data.pass_b <= pb;
    data.oa <= by ? pa : oa;
    data.bypass <= by;
    data.zero <= (oa == 8'd0);
  end

endmodule

[rtl/pab_div_cell.sv]
module pab_div_cell
  import pab_pkg::*;
#(
  parameter int unsigned Bit = 0
)
(
  input  logic clk,
  input  logic rst,
  input  logic in_vld,
  input  div_data_t in_data,
  output logic out_vld,
  output div_data_t out_data
);

  function automatic logic [QuoW-1:0] step_q(input logic [QuoW-1:0] q,
                                             input logic [NumW-1:0] rem,
                                             input logic [DenW-1:0] den);
    logic [NumW+QuoW-1:0] trial;
    trial = {{(NumW+QuoW-DenW){1'b0}}, den} << Bit;
    step_q = q;
    if ({{QuoW{1'b0}}, rem} >= trial) step_q[Bit] = 1'b1;
  endfunction

  function automatic logic [NumW-1:0] step_r(input logic [NumW-1:0] rem,
                                             input logic [DenW-1:0] den);
    logic [NumW+QuoW-1:0] trial;
    trial = {{(NumW+QuoW-DenW){1'b0}}, den} << Bit;
    step_r = rem;
    if ({{QuoW{1'b0}}, rem} >= trial) step_r = rem - NumW'(trial);
  endfunction

  // top cell seeds the remainder with the rounded numerator
  logic [NumW-1:0] rr, rg, rb;
  always_comb begin
    if (Bit == QuoW - 1) begin
      rr = in_data.num_r + NumW'(in_data.den >> 1);
      rg = in_data.num_g + NumW'(in_data.den >> 1);
      rb = in_data.num_b + NumW'(in_data.den >> 1);
    end else begin
      rr = in_data.rem_r;
      rg = in_data.rem_g;
      rb = in_data.rem_b;
    end
  end

  div_data_t data_next;
  always_comb begin
    data_next = in_data;
    data_next.q_r = step_q(in_data.q_r, rr, in_data.den);
    data_next.q_g = step_q(in_data.q_g, rg, in_data.den);
    data_next.q_b = step_q(in_data.q_b, rb, in_data.den);
    data_next.rem_r = step_r(rr, in_data.den);
    data_next.rem_g = step_r(rg, in_data.den);
    data_next.rem_b = step_r(rb, in_data.den);
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else out_vld <= in_vld;
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

[tb/pixel_alpha_blend_unit_tb.sv]
module pixel_alpha_blend_unit_tb;
  import pab_pkg::*;

  typedef struct packed {
    logic [7:0] sr, sg, sb, sa, dr, dg, db, da;
  } pixel_pair_t;

  typedef struct packed {
    logic [7:0] r, g, b, a;
  } blend_px_t;

  typedef struct {
    pixel_pair_t px;
    logic        has_exp;
    blend_px_t   want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [7:0] src_red = 8'd0, src_green = 8'd0, src_blue = 8'd0, src_alpha = 8'd0;
  logic [7:0] dst_red = 8'd0, dst_green = 8'd0, dst_blue = 8'd0, dst_alpha = 8'd0;
  logic done;
  logic [7:0] out_red, out_green, out_blue, out_alpha;

  blend_px_t blend_q[$];
  int        err_cnt = 0;
  int        idle_pct = 0;

  pixel_alpha_blend_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .src_red(src_red), .src_green(src_green), .src_blue(src_blue),
    .src_alpha(src_alpha), .dst_red(dst_red), .dst_green(dst_green),
    .dst_blue(dst_blue), .dst_alpha(dst_alpha), .done(done),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_alpha(out_alpha)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] mix_chan(int unsigned sc, int unsigned dc, int unsigned sa,
                                          int unsigned da, int unsigned den);
    int unsigned num;
    int unsigned q;
    num = sc * sa * ChMax + dc * da * (ChMax - sa);
    q = (num + den / 2) / den;
    return (q > ChMax) ? 8'(ChMax) : 8'(q);
  endfunction

  function automatic blend_px_t blend_px(pixel_pair_t p);
    blend_px_t   o;
    int unsigned oa;
    int unsigned den;
    if (p.sa == 8'd0) begin
      o = '{p.dr, p.dg, p.db, p.da};
    end else if (p.sa == 8'd255) begin
      o = '{p.sr, p.sg, p.sb, p.sa};
    end else begin
      oa = p.sa + (p.da * (ChMax - p.sa) + RoundAlpha) / ChMax;
      if (oa > ChMax) oa = ChMax;
      if (oa == 0) begin
        o = '0;
      end else begin
        den = oa * ChMax;
        o.r = mix_chan(p.sr, p.dr, p.sa, p.da, den);
        o.g = mix_chan(p.sg, p.dg, p.sa, p.da, den);
        o.b = mix_chan(p.sb, p.db, p.sa, p.da, den);
        o.a = 8'(oa);
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("error: %s got %0d want %0d", what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    blend_px_t w;
    if (!rst && done) begin
      if (blend_q.size() == 0) begin
        $display("error: unexpected item %0d %0d %0d %0d",
                 out_red, out_green, out_blue, out_alpha);
        err_cnt++;
      end else begin
        w = blend_q.pop_front();
        if (out_red !== w.r) report_mismatch("out_red", out_red, w.r);
        if (out_green !== w.g) report_mismatch("out_green", out_green, w.g);
        if (out_blue !== w.b) report_mismatch("out_blue", out_blue, w.b);
        if (out_alpha !== w.a) report_mismatch("out_alpha", out_alpha, w.a);
      end
    end
  end

  task automatic send_pixel(pixel_pair_t p, blend_px_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    {src_red, src_green, src_blue, src_alpha,
     dst_red, dst_green, dst_blue, dst_alpha} <= p;
    blend_q.push_back(want);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(1, 4));
      3: return 8'($urandom_range(251, 254));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("pixel_alpha_blend_unit: mismatch");
    $finish;
  end

  initial begin
    dir_row_t    dir[$];
    pixel_pair_t p;
    int          wait_cnt;
    dir.push_back('{'{8'd10, 8'd20, 8'd30, 8'd0, 8'd40, 8'd50, 8'd60, 8'd70},
                    1'b1, '{8'd40, 8'd50, 8'd60, 8'd70}});
    dir.push_back('{'{8'd11, 8'd22, 8'd33, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4},
                    1'b1, '{8'd11, 8'd22, 8'd33, 8'd255}});
    dir.push_back('{'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
                    1'b1, '{8'd0, 8'd0, 8'd0, 8'd0}});
    dir.push_back('{'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
                    1'b1, '{8'd0, 8'd0, 8'd0, 8'd255}});
    dir.push_back('{'{8'd255, 8'd255, 8'd255, 8'd1, 8'd255, 8'd255, 8'd255, 8'd255},
                    1'b0, '0});
    dir.push_back('{'{8'd255, 8'd255, 8'd255, 8'd254, 8'd255, 8'd255, 8'd255, 8'd0},
                    1'b0, '0});
    dir.push_back('{'{8'd0, 8'd0, 8'd0, 8'd1, 8'd255, 8'd255, 8'd255, 8'd0},
                    1'b0, '0});
    dir.push_back('{'{8'd255, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd0, 8'd128},
                    1'b0, '0});
    dir.push_back('{'{8'd255, 8'd255, 8'd255, 8'd127, 8'd255, 8'd255, 8'd255, 8'd1},
                    1'b0, '0});
    dir.push_back('{'{8'd0, 8'd0, 8'd0, 8'd254, 8'd0, 8'd0, 8'd0, 8'd255},
                    1'b0, '0});
    dir.push_back('{'{8'd1, 8'd254, 8'd128, 8'd64, 8'd254, 8'd1, 8'd127, 8'd192},
                    1'b0, '0});
    dir.push_back('{'{8'd255, 8'd255, 8'd255, 8'd2, 8'd255, 8'd255, 8'd255, 8'd254},
                    1'b0, '0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir[i]) begin
      send_pixel(dir[i].px, dir[i].has_exp ? dir[i].want : blend_px(dir[i].px));
    end

    for (int n = 0; n < 1750; n++) begin
      case (n / 440)
        0: idle_pct = 0;
        1: idle_pct = 60;
        2: idle_pct = 0;
        default: idle_pct = 19;
      endcase
      if (n == 900) begin
        start <= 1'b0;
        wait_cnt = 0;
        while (blend_q.size() != 0 && wait_cnt < 1000) begin
          @(posedge clk);
          wait_cnt++;
        end
      end
      p = {rand_chan(), rand_chan(), rand_chan(), rand_chan(),
           rand_chan(), rand_chan(), rand_chan(), rand_chan()};
      send_pixel(p, blend_px(p));
    end
    start <= 1'b0;

    wait_cnt = 0;
    while (blend_q.size() != 0 && wait_cnt < 2000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (20) @(posedge clk);

    if (err_cnt == 0 && blend_q.size() == 0) begin
      $display("pixel_alpha_blend_unit: match");
    end else begin
      $display("pixel_alpha_blend_unit: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pab_pkg.sv
rtl/pab_prep.sv
rtl/pab_div_cell.sv
rtl/pixel_alpha_blend_unit.sv
tb/pixel_alpha_blend_unit_tb.sv
